// ===== rtl/sccif_pkg.sv =====
`default_nettype none
package sccif_pkg;

  // bus access kinds
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_STROBE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // command codes (low nibble of the active command)
  localparam logic [3:0] CMD_HOLD     = 4'd0;
  localparam logic [3:0] CMD_SHIFT    = 4'd1;
  localparam logic [3:0] CMD_TIME_SET = 4'd2;
  localparam logic [3:0] CMD_TIME_RD  = 4'd3;
  // latched code that takes the serial command instead
  localparam logic [2:0] CMD_SERIAL   = 3'd7;

  // strobe bits
  localparam int STB_EXEC  = 1;
  localparam int STB_SHIFT = 2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] write_data;
    logic [6:0] now_year;
    logic [3:0] now_month;
    logic [2:0] now_weekday;
    logic [4:0] now_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } item_t;

  typedef struct packed {
    logic [4:0]  read_data;
    logic        time_set_pulse;
    logic [47:0] set_image;
    logic        set_with_year;
  } result_t;

  // binary to BCD for 0..99; tens by reciprocal multiply (205/2048)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {11'd0, v} * 18'd205;
    tens  = prod[14:11];
    units = v - 7'({3'd0, tens} * 7'd10);
    return {tens, units[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/serial_calendar_clock_interface.sv =====
// Bus front end of a serial calendar-clock chip.
// Input channel (in_valid/in_ready): one beat per bus access. mode selects
// a command-port write, a strobe-port write or a data-port read;
// write_data is the byte written; now_* is the current time in binary.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: read_data (bit 4 = low chain bit on reads in output
// mode), and time_set_pulse with the 48-bit set_image and set_with_year
// when the access ran a time set command.
// Path: an access passes the input register, then state + result register.
// Throughput: 1 beat per cycle when out_ready is high; all work on an
// access is one pass of short logic between input and result register.
// Stall: while out_ready is low the result register holds, one more beat
// waits in the input register, then in_ready drops.
// Reset (rst, synchronous): clears both pipeline valids, clears the
// command latch, strobe history, serial command and time registers,
// sets hold and the extended-command bit, clears output mode.
`default_nettype none
module serial_calendar_clock_interface
  import sccif_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  write_data,
  input  wire logic [6:0]  now_year,
  input  wire logic [3:0]  now_month,
  input  wire logic [2:0]  now_weekday,
  input  wire logic [4:0]  now_day,
  input  wire logic [4:0]  now_hour,
  input  wire logic [5:0]  now_minute,
  input  wire logic [5:0]  now_second,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       read_data,
  output logic             time_set_pulse,
  output logic [47:0]      set_image,
  output logic             set_with_year
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_ready;
  result_t res;

  assign in_item = '{
    mode:        mode,
    write_data:  write_data,
    now_year:    now_year,
    now_month:   now_month,
    now_weekday: now_weekday,
    now_day:     now_day,
    now_hour:    now_hour,
    now_minute:  now_minute,
    now_second:  now_second
  };

  // input register
  sccif_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item)
  );

  // chip state, decode and result register
  sccif_core u_core (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign read_data      = res.read_data;
  assign time_set_pulse = res.time_set_pulse;
  assign set_image      = res.set_image;
  assign set_with_year  = res.set_with_year;

endmodule
`default_nettype wire

// ===== rtl/sccif_in_stage.sv =====
`default_nettype none
module sccif_in_stage
  import sccif_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       s1_valid,
  input  wire logic  s1_ready,
  output item_t      s1_item
);

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sccif_core.sv =====
`default_nettype none
module sccif_core
  import sccif_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s1_valid,
  output logic       s1_ready,
  input  wire item_t s1_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    res
);

  logic [2:0]      pending_command, pending_command_next;
  logic            data_in_bit, data_in_bit_next;
  logic [7:0]      last_strobe, last_strobe_next;
  logic            act_ext, act_ext_next;      // set when the active command is the serial one
  logic [3:0]      serial_command, serial_command_next;
  logic            hold_flag, hold_flag_next;
  logic            output_mode, output_mode_next;
  logic [5:0][7:0] time_regs, time_regs_next;
  result_t         res_next;

  logic       adv;
  logic [7:0] rise;
  logic       exec_ext;
  logic [3:0] exec_code;
  logic [52:0] chain_ext;
  logic [40:0] chain_std;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign s1_ready = !out_valid || out_ready;

  always_comb begin
    pending_command_next = pending_command;
    data_in_bit_next     = data_in_bit;
    last_strobe_next     = last_strobe;
    act_ext_next         = act_ext;
    serial_command_next  = serial_command;
    hold_flag_next       = hold_flag;
    output_mode_next     = output_mode;
    time_regs_next       = time_regs;
    res_next             = '0;
    rise      = (last_strobe ^ s1_item.write_data) & s1_item.write_data;
    exec_ext  = (pending_command == CMD_SERIAL);
    exec_code = exec_ext ? serial_command : {1'b0, pending_command};
    chain_ext = '0;
    chain_std = '0;
    case (s1_item.mode)
      MODE_CMD: begin
        pending_command_next = s1_item.write_data[2:0];
        data_in_bit_next     = s1_item.write_data[3];
      end
      MODE_STROBE: begin
        last_strobe_next = s1_item.write_data;
        if (rise[STB_EXEC]) begin
          act_ext_next = exec_ext;
          case (exec_code)
            CMD_HOLD: begin
              hold_flag_next   = 1'b1;
              output_mode_next = 1'b0;
            end
            CMD_SHIFT: begin
              hold_flag_next   = 1'b0;
              output_mode_next = 1'b1;
            end
            CMD_TIME_SET: begin
              res_next.time_set_pulse = 1'b1;
              res_next.set_image      = time_regs;
              res_next.set_with_year  = exec_ext;
              hold_flag_next          = 1'b1;
              output_mode_next        = 1'b1;
            end
            CMD_TIME_RD: begin
              time_regs_next[5] = to_bcd(s1_item.now_year);
              time_regs_next[4] = {s1_item.now_month, 1'b0, s1_item.now_weekday};
              time_regs_next[3] = to_bcd({2'd0, s1_item.now_day});
              time_regs_next[2] = to_bcd({2'd0, s1_item.now_hour});
              time_regs_next[1] = to_bcd({1'b0, s1_item.now_minute});
              time_regs_next[0] = to_bcd({1'b0, s1_item.now_second});
              hold_flag_next    = 1'b1;
              output_mode_next  = 1'b0;
            end
            default: ;
          endcase
        end
        // shift runs after the command in the same beat
        if (rise[STB_SHIFT]) begin
          if (hold_flag_next) begin
            if (act_ext_next) begin
              serial_command_next = {data_in_bit, serial_command_next[3:1]};
            end
          end else if (act_ext_next) begin
            chain_ext           = {data_in_bit, serial_command_next, time_regs_next};
            serial_command_next = chain_ext[52:49];
            time_regs_next      = chain_ext[48:1];
          end else begin
            chain_std           = {data_in_bit, time_regs_next[4:0]};
            time_regs_next[4:0] = chain_std[40:1];
          end
        end
      end
      MODE_READ: begin
        if (output_mode) begin
          res_next.read_data = {time_regs[0][0], 4'd0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_command <= '0;
      data_in_bit     <= 1'b0;
      last_strobe     <= '0;
      act_ext         <= 1'b1;
      serial_command  <= '0;
      hold_flag       <= 1'b1;
      output_mode     <= 1'b0;
      time_regs       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (adv) begin
        pending_command <= pending_command_next;
        data_in_bit     <= data_in_bit_next;
        last_strobe     <= last_strobe_next;
        act_ext         <= act_ext_next;
        serial_command  <= serial_command_next;
        hold_flag       <= hold_flag_next;
        output_mode     <= output_mode_next;
        time_regs       <= time_regs_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  // shifting out is only reachable with output enabled
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    !hold_flag |-> output_mode) else $error("hold clear without output mode");

  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.time_set_pulse |-> res.read_data == 5'd0)
    else $error("time set and read data in one beat");

  a_img_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.time_set_pulse |-> res.set_image == 48'd0 && !res.set_with_year)
    else $error("set image without pulse");

  a_set_state: assert property (@(posedge clk) disable iff (rst)
    adv && res_next.time_set_pulse |=> hold_flag && output_mode)
    else $error("time set left wrong flags");

endmodule
`default_nettype wire
